// File: design/sdfph_pkg.sv
// Shared types, constants and helpers for the decimal-field to hex-text converter.
`default_nettype none
package sdfph_pkg;

  // One input character and its line-start flag
  typedef struct packed {
    logic [7:0] char_code;
    logic       start_of_line;
  } in_item_t;

  // One output character and its end-of-run flag
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  localparam int unsigned WordWidth     = 32;
  localparam int unsigned AccWidth      = 16;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

  // Line layout: five fields of six slots (sign, four digits, separator)
  localparam logic [2:0] SlotSign  = 3'd0;
  localparam logic [2:0] SlotLastDigit = 3'd4;
  localparam logic [2:0] SlotLast  = 3'd5;
  localparam logic [2:0] FieldLast = 3'd4;

  // Output run: '0', 'x', eight hex digits, newline
  localparam logic [3:0] IdxZero    = 4'd0;
  localparam logic [3:0] IdxX       = 4'd1;
  localparam logic [3:0] IdxNewline = 4'd10;

  localparam logic [7:0] CharMinus   = 8'h2D;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharX       = 8'h78;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharUpperA  = 8'h41;

  // Map a nibble to its uppercase ASCII hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib >= 4'd10) begin
      res = CharUpperA + {4'd0, nib} - 8'd10;
    end else begin
      res = CharZero + {4'd0, nib};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: design/sdfph_front.sv
// Front end: tracks line position, accumulates signed fields, packs the word.
`default_nettype none
module sdfph_front
  import sdfph_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire in_item_t             item_i,
  output logic                      word_valid_o,
  output logic [WordWidth-1:0]      word_o
);

  logic [2:0]           slot_q, slot_d;
  logic [2:0]           field_q, field_d;
  logic                 neg_q, neg_d;
  logic [AccWidth-1:0]  acc_q, acc_d;
  logic [WordWidth-1:0] word_q, word_d;

  logic [2:0]           slot_cur, field_cur;
  logic [AccWidth-1:0]  acc_next, val;
  logic [WordWidth-1:0] word_base, field_bits;

  // Resolve the current position, honoring a forced line start
  always_comb begin
    slot_cur  = item_i.start_of_line ? SlotSign : slot_q;
    field_cur = item_i.start_of_line ? 3'd0 : field_q;
  end

  // Accumulate acc*10 + (char - '0') modulo 2^16 and apply the sign
  always_comb begin
    acc_next = (acc_q << 3) + (acc_q << 1) + {8'd0, item_i.char_code}
               - AccWidth'(CharZero);
    val      = neg_q ? (AccWidth'(0) - acc_next) : acc_next;
  end

  // Mask and place the finished field
  always_comb begin
    case (field_cur)
      3'd0:    field_bits = {29'd0, val[2:0]};
      3'd1:    field_bits = {21'd0, val[7:0], 3'd0};
      3'd2:    field_bits = {16'd0, val[4:0], 11'd0};
      3'd3:    field_bits = {11'd0, val[4:0], 16'd0};
      3'd4:    field_bits = {val[10:0], 21'd0};
      default: field_bits = '0;
    endcase
  end

  // Next state for an accepted character
  always_comb begin
    slot_d       = slot_q;
    field_d      = field_q;
    neg_d        = neg_q;
    acc_d        = acc_q;
    word_d       = word_q;
    word_valid_o = 1'b0;
    word_base    = (slot_cur == SlotSign && field_cur == 3'd0) ? '0 : word_q;
    if (accept_i) begin
      word_d = word_base;
      if (slot_cur == SlotSign) begin
        neg_d = (item_i.char_code == CharMinus);
        acc_d = '0;
      end else if (slot_cur <= SlotLastDigit) begin
        acc_d = acc_next;
        if (slot_cur == SlotLastDigit) begin
          word_d = word_base | field_bits;
          word_valid_o = (field_cur == FieldLast);
        end
      end
      // Advance position; wrap after the last separator
      if (slot_cur == SlotLast) begin
        slot_d  = SlotSign;
        field_d = (field_cur == FieldLast) ? 3'd0 : field_cur + 3'd1;
      end else begin
        slot_d  = slot_cur + 3'd1;
        field_d = field_cur;
      end
    end
  end

  assign word_o = word_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= SlotSign;
      field_q <= 3'd0;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      word_q  <= '0;
    end else begin
      slot_q  <= slot_d;
      field_q <= field_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      word_q  <= word_d;
    end
  end

endmodule
`default_nettype wire

// File: design/sdfph_queue.sv
// Two-entry queue of packed words between the front and back ends.
`default_nettype none
module sdfph_queue
  import sdfph_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_i,
  input  wire logic [WordWidth-1:0] wr_data_i,
  input  wire logic                 rd_i,
  output logic [WordWidth-1:0]      rd_data_o,
  output logic                      full_o,
  output logic                      empty_o
);

  logic [WordWidth-1:0]     mem_q [QueueDepth];
  logic [QueuePtrWidth-1:0] wptr_q, rptr_q;
  logic [QueuePtrWidth:0]   count_q;

  assign full_o    = (count_q == (QueuePtrWidth+1)'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rptr_q];

  // Store a word
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= wptr_q + QueuePtrWidth'(1);
      end
      if (rd_i) begin
        rptr_q <= rptr_q + QueuePtrWidth'(1);
      end
      count_q <= count_q + (QueuePtrWidth+1)'(wr_i) - (QueuePtrWidth+1)'(rd_i);
    end
  end

endmodule
`default_nettype wire

// File: design/sdfph_back.sv
// Back end: expands one packed word into the eleven-character hex run.
`default_nettype none
module sdfph_back
  import sdfph_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_empty_i,
  input  wire logic [WordWidth-1:0] q_data_i,
  output logic                      q_rd_o,
  input  wire logic                 pop_i,
  output logic                      empty_o,
  output out_item_t                 out_o
);

  logic                 busy_q, busy_d;
  logic [3:0]           idx_q, idx_d;
  logic [WordWidth-1:0] word_q, word_d;
  logic [2:0]           nib_sel;
  logic                 done;

  assign empty_o = !busy_q;
  assign done    = busy_q && pop_i && (idx_q == IdxNewline);

  // Load the next word when idle or when the current run finishes
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    word_d = word_q;
    q_rd_o = 1'b0;
    if (!busy_q || done) begin
      busy_d = !q_empty_i;
      q_rd_o = !q_empty_i;
      idx_d  = IdxZero;
      word_d = q_data_i;
    end else if (pop_i) begin
      idx_d = idx_q + 4'd1;
    end
  end

  // Select the character for the current index
  always_comb begin
    nib_sel = 3'(4'd9 - idx_q);
    out_o.last_char = (idx_q == IdxNewline);
    case (idx_q) inside
      IdxZero:    out_o.out_char = CharZero;
      IdxX:       out_o.out_char = CharX;
      [4'd2:4'd9]: out_o.out_char = hex_char(word_q[{nib_sel, 2'b00} +: 4]);
      IdxNewline: out_o.out_char = CharNewline;
      default:    out_o.out_char = CharNewline;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= IdxZero;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule
`default_nettype wire

// File: design/signed_decimal_fields_to_packed_hex_core.sv
// Top level: decimal-field line parser feeding a hex text serializer.
//
// Input channel: one ASCII character per request (push/full). A line holds
// five fields of a sign and four digits at positions 6k..6k+4; other
// positions are separators. start_of_line forces position 0.
// Output channel: empty/pop queue of characters. After the last digit of a
// line the block offers "0x", eight uppercase hex digits of the packed word
// and a newline flagged by last_char.
// Throughput: one character per cycle on input while full is low. After the
// edge that accepts the last digit, the word is written into the queue and
// then loaded into the serializer, and empty falls; the run then drains at
// one character per cycle while pop is high, and a queued word starts its run right after a newline.
// A two-word queue sits between the parser and the serializer, so parsing
// continues while the receiver stalls; full rises only when two finished
// words wait behind a stalled run.
// Reset clears the position, accumulator, packed word, queue and run.
`default_nettype none
module signed_decimal_fields_to_packed_hex_core
  import sdfph_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  in_data_i,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      out_data_o
);

  logic                 accept;
  logic                 word_valid;
  logic [WordWidth-1:0] word;
  logic                 q_rd, q_empty;
  logic [WordWidth-1:0] q_data;

  assign accept = push && !full;

  sdfph_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (in_data_i),
    .word_valid_o (word_valid),
    .word_o       (word)
  );

  sdfph_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (word_valid),
    .wr_data_i (word),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  sdfph_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_o     (out_data_o)
  );

endmodule
`default_nettype wire
